// ===== rtl/rk4_pkg.sv =====
package rk4_pkg;

    localparam int DATA_W   = 32;
    localparam int COEF_W   = 31;
    localparam int CFG_IDX_W = 3;
    localparam int AX_W     = 2;
    localparam int MAX_AXES = 3;
    localparam int DEF_AXES = 3;
    localparam int DEF_FRAC_BITS = 16;

    // shared multiplier operand and product widths
    localparam int MA_W = 36;
    localparam int MB_W = 33;
    localparam int P_W  = MA_W + MB_W;
    localparam int NET_W = 64;
    localparam int ACC_W = 36;

    // time factors, unsigned Q0.32
    localparam logic [31:0] DT_Q32       = 32'd4294967;
    localparam logic [31:0] HALF_DT_Q32  = 32'd2147484;
    localparam logic [31:0] SIXTH_DT_Q32 = 32'd715828;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_Y   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_Z   = 3'd7;

    localparam logic [COEF_W-1:0] ONE_Q16 = 31'd65536;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [NET_W-1:0] v);
        logic signed [NET_W-1:0] hi;
        logic signed [NET_W-1:0] lo;
        hi = NET_W'(64'sd2147483647);
        lo = -NET_W'(64'sd2147483648);
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[DATA_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/rk4_mul.sv =====
module rk4_mul (
    input  logic                              i_clk,
    input  logic signed [rk4_pkg::MA_W-1:0]   i_a,
    input  logic signed [rk4_pkg::MB_W-1:0]   i_b,
    output logic signed [rk4_pkg::P_W-1:0]    o_p
);
    import rk4_pkg::*;

    logic signed [P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/rk4_damped_spring_step.sv =====
// Channel  | valid       | stall        | payload
// input    | i_in_valid  | o_in_stall   | i_req_type, i_start_x/y/z
// output   | o_out_valid | i_out_stall  | o_pos_*, o_vel_*, o_acc_*
// config   | i_cfg_we    | (none)       | i_cfg_idx, i_cfg_data
//
// A restart puts its result in the output register when it is accepted.
// An advance runs each axis in turn through one shared registered multiplier:
// per axis a load, five derivative evaluations, three stage updates, one
// accumulate for the last stage and a final update. The result is registered
// once the last axis has finished its final derivative evaluation.
// Reset (synchronous) clears position, velocity and acceleration and loads the
// register defaults. No new transaction is taken until the result has left the
// output register.
module rk4_damped_spring_step #(
    parameter int AXES      = rk4_pkg::DEF_AXES,
    parameter int FRAC_BITS = rk4_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rk4_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rk4_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [rk4_pkg::DATA_W-1:0]   i_start_x,
    input  logic signed [rk4_pkg::DATA_W-1:0]   i_start_y,
    input  logic signed [rk4_pkg::DATA_W-1:0]   i_start_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_pos_x,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_pos_y,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_pos_z,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_vel_x,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_vel_y,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_vel_z,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_acc_x,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_acc_y,
    output logic signed [rk4_pkg::DATA_W-1:0]   o_acc_z
);
    import rk4_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_AC0  = 4'd2;
    localparam logic [3:0] S_AC1  = 4'd3;
    localparam logic [3:0] S_AC2  = 4'd4;
    localparam logic [3:0] S_AC3  = 4'd5;
    localparam logic [3:0] S_AC4  = 4'd6;
    localparam logic [3:0] S_TS0  = 4'd7;
    localparam logic [3:0] S_TS1  = 4'd8;
    localparam logic [3:0] S_TS2  = 4'd9;
    localparam logic [3:0] S_FN0  = 4'd10;
    localparam logic [3:0] S_FN1  = 4'd11;
    localparam logic [3:0] S_FN2  = 4'd12;

    localparam logic [2:0] STG_LAST = 3'd3;
    localparam logic [2:0] STG_POST = 3'd4;
    localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

    localparam logic signed [P_W-1:0] Q_HALF = P_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [P_W-1:0] T_HALF = P_W'(1) <<< 31;

    logic [3:0]                r_st;
    logic [2:0]                r_stg;
    logic [AX_W-1:0]           r_ax;
    logic                      r_ovld;

    logic [COEF_W-1:0]         r_k;
    logic [COEF_W-1:0]         r_c;
    logic [COEF_W-1:0]         r_inv [MAX_AXES];
    logic signed [DATA_W-1:0]  r_force [MAX_AXES];

    logic signed [DATA_W-1:0]  r_pos [MAX_AXES];
    logic signed [DATA_W-1:0]  r_vel [MAX_AXES];
    logic signed [DATA_W-1:0]  r_acc [MAX_AXES];

    logic signed [DATA_W-1:0]  r_x0, r_v0, r_xs, r_vs, r_kv, r_nsat;
    logic signed [NET_W-1:0]   r_net;
    logic signed [ACC_W-1:0]   r_sx, r_sv;

    logic signed [MA_W-1:0]    w_ma;
    logic signed [MB_W-1:0]    w_mb;
    logic signed [P_W-1:0]     w_prod;
    logic signed [P_W-1:0]     w_rq_full, w_rt_full;
    logic signed [NET_W-1:0]   w_rq, w_rt;
    logic [31:0]               w_h;
    logic                      w_wide;
    logic signed [DATA_W-1:0]  w_new;
    logic                      w_accept;

    rk4_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_rq_full = (w_prod + Q_HALF) >>> FRAC_BITS;
    assign w_rt_full = (w_prod + T_HALF) >>> 32;
    assign w_rq = w_rq_full[NET_W-1:0];
    assign w_rt = w_rt_full[NET_W-1:0];
    assign w_h = (r_stg == 3'd2) ? DT_Q32 : HALF_DT_Q32;
    assign w_wide = (r_stg == 3'd1) || (r_stg == 3'd2);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            S_AC0: begin
                w_ma = MA_W'(r_vs);
                w_mb = MB_W'({2'b00, r_c});
            end
            S_AC1: begin
                w_ma = MA_W'(r_xs);
                w_mb = MB_W'({2'b00, r_k});
            end
            S_AC3: begin
                w_ma = MA_W'(r_nsat);
                w_mb = MB_W'({2'b00, r_inv[r_ax]});
            end
            S_TS0: begin
                w_ma = MA_W'(r_vs);
                w_mb = MB_W'({1'b0, w_h});
            end
            S_TS1: begin
                w_ma = MA_W'(r_kv);
                w_mb = MB_W'({1'b0, w_h});
            end
            S_FN0: begin
                w_ma = r_sx;
                w_mb = MB_W'({1'b0, SIXTH_DT_Q32});
            end
            S_FN1: begin
                w_ma = r_sv;
                w_mb = MB_W'({1'b0, SIXTH_DT_Q32});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // sum of old value and the rounded time product; x in FN1/TS1, v in FN2/TS2
    always_comb begin
        if ((r_st == S_TS1) || (r_st == S_FN1)) begin
            w_new = sat32(NET_W'(r_x0) + w_rt);
        end else begin
            w_new = sat32(NET_W'(r_v0) + w_rt);
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= ONE_Q16;
            r_c <= '0;
            for (int i = 0; i < MAX_AXES; i++) begin
                r_inv[i]   <= ONE_Q16;
                r_force[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STIFFNESS: r_k        <= i_cfg_data[COEF_W-1:0];
                REG_DAMPING:   r_c        <= i_cfg_data[COEF_W-1:0];
                REG_INV_X:     r_inv[0]   <= i_cfg_data[COEF_W-1:0];
                REG_INV_Y:     r_inv[1]   <= i_cfg_data[COEF_W-1:0];
                REG_INV_Z:     r_inv[2]   <= i_cfg_data[COEF_W-1:0];
                REG_FORCE_X:   r_force[0] <= i_cfg_data;
                REG_FORCE_Y:   r_force[1] <= i_cfg_data;
                REG_FORCE_Z:   r_force[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_stg  <= '0;
            r_ax   <= '0;
            r_ovld <= 1'b0;
            for (int i = 0; i < MAX_AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
        end else begin
            if (r_ovld && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_req_type) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_vel[i] <= '0;
                                r_acc[i] <= '0;
                            end
                            r_pos[0] <= i_start_x;
                            if (AXES > 1) r_pos[1] <= i_start_y;
                            if (AXES > 2) r_pos[2] <= i_start_z;
                            r_ovld <= 1'b1;
                        end else begin
                            r_ax <= '0;
                            r_st <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_x0  <= r_pos[r_ax];
                    r_v0  <= r_vel[r_ax];
                    r_xs  <= r_pos[r_ax];
                    r_vs  <= r_vel[r_ax];
                    r_sx  <= '0;
                    r_sv  <= '0;
                    r_stg <= '0;
                    r_st  <= S_AC0;
                end
                S_AC0: r_st <= S_AC1;
                S_AC1: begin
                    r_net <= NET_W'(r_force[r_ax]) - w_rq;
                    r_st  <= S_AC2;
                end
                S_AC2: begin
                    r_nsat <= sat32(r_net - w_rq);
                    r_st   <= S_AC3;
                end
                S_AC3: r_st <= S_AC4;
                S_AC4: begin
                    if (r_stg == STG_POST) begin
                        r_acc[r_ax] <= sat32(w_rq);
                        if (r_ax == AX_LAST) begin
                            r_ovld <= 1'b1;
                            r_st   <= S_IDLE;
                        end else begin
                            r_ax <= r_ax + 1'b1;
                            r_st <= S_LOAD;
                        end
                    end else begin
                        r_kv <= sat32(w_rq);
                        r_st <= S_TS0;
                    end
                end
                S_TS0: begin
                    // weights 1, 2, 2, 1 over the four derivative evaluations
                    if (w_wide) begin
                        r_sx <= r_sx + (ACC_W'(r_vs) <<< 1);
                        r_sv <= r_sv + (ACC_W'(r_kv) <<< 1);
                    end else begin
                        r_sx <= r_sx + ACC_W'(r_vs);
                        r_sv <= r_sv + ACC_W'(r_kv);
                    end
                    r_st <= (r_stg == STG_LAST) ? S_FN0 : S_TS1;
                end
                S_TS1: begin
                    r_xs <= w_new;
                    r_st <= S_TS2;
                end
                S_TS2: begin
                    r_vs  <= w_new;
                    r_stg <= r_stg + 1'b1;
                    r_st  <= S_AC0;
                end
                S_FN0: r_st <= S_FN1;
                S_FN1: begin
                    r_xs        <= w_new;
                    r_pos[r_ax] <= w_new;
                    r_st        <= S_FN2;
                end
                S_FN2: begin
                    r_vs        <= w_new;
                    r_vel[r_ax] <= w_new;
                    r_stg       <= STG_POST;
                    r_st        <= S_AC0;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_st != S_IDLE) || r_ovld;
    assign o_out_valid = r_ovld;
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_vel_x = r_vel[0];
    assign o_vel_y = r_vel[1];
    assign o_vel_z = r_vel[2];
    assign o_acc_x = r_acc[0];
    assign o_acc_y = r_acc[1];
    assign o_acc_z = r_acc[2];

endmodule
